### hdl/wto_pkg.sv
// Shared types, constants and table builder for the wavetable oscillator.
// No dependencies; every other file refers to it by scoped names.
package wto_pkg;

	localparam int PHASE_BITS       = 32;
	localparam int GAIN_BITS        = 16;
	localparam int WAVE_SEL_BITS    = 3;
	localparam int CFG_INDEX_BITS   = 2;
	localparam int CFG_DATA_BITS    = 32;

	localparam int TABLE_SIZE       = 1024;
	localparam int INDEX_BITS       = $clog2(TABLE_SIZE);
	localparam int QTR_SIZE         = TABLE_SIZE / 4;
	localparam int QTR_BITS         = $clog2(QTR_SIZE);
	localparam int CUSTOM_DEPTH     = 1024;
	localparam int CUSTOM_ADDR_BITS = $clog2(CUSTOM_DEPTH);

	localparam int VALUE_BITS       = 16;
	localparam int SAMPLE_BITS      = 16;
	// internal waveform value, full scale 1.0 = 32768, needs one bit above Q1.15
	localparam int WAVE_BITS        = 17;
	localparam int PROD_BITS        = WAVE_BITS + GAIN_BITS + 1;
	localparam int GAIN_SHIFT       = 14;
	localparam int SAW_SHIFT        = 16 - INDEX_BITS;
	localparam int TRI_SHIFT        = 17 - INDEX_BITS;

	localparam int QUEUE_DEPTH      = 4;

	// waveform register codes
	localparam logic [WAVE_SEL_BITS-1:0] WAVE_SINE     = 3'd0;
	localparam logic [WAVE_SEL_BITS-1:0] WAVE_SQUARE   = 3'd1;
	localparam logic [WAVE_SEL_BITS-1:0] WAVE_SAWTOOTH = 3'd2;
	localparam logic [WAVE_SEL_BITS-1:0] WAVE_TRIANGLE = 3'd3;
	localparam logic [WAVE_SEL_BITS-1:0] WAVE_CUSTOM   = 3'd4;

	// configuration register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_STEP = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN       = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WAVEFORM   = 2'd2;

	localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd16384;

	// one classified request on its way from front to back
	typedef struct packed {
		logic                         is_write;
		logic [INDEX_BITS-1:0]        index;   // table index of a tick, entry of a write
		logic signed [VALUE_BITS-1:0] value;
	} op_t;

	typedef struct packed {
		logic [GAIN_BITS-1:0]     gain;
		logic [WAVE_SEL_BITS-1:0] waveform;
	} back_cfg_t;

	// quarter-wave sine magnitude, entry r = sin(pi/2 * r / QTR_SIZE), 1.0 = 32768
	typedef logic [15:0] qtab_t [0:QTR_SIZE];

	localparam logic [63:0] Q30_ONE     = 64'd1073741824;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam int          TAYLOR_DIVS [5] = '{110, 72, 42, 20, 6};

	function automatic qtab_t make_qtab();
		qtab_t       tab;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		int          r;
		int          k;
		for (r = 0; r <= QTR_SIZE; r++) begin
			x  = (64'(r) * HALF_PI_Q30) >> QTR_BITS;
			x2 = (x * x) >> 30;
			t  = Q30_ONE;
			for (k = 0; k < 5; k++) begin
				t = Q30_ONE - (((x2 * t) >> 30) / 64'(TAYLOR_DIVS[k]));
			end
			tab[r] = 16'((((x * t) >> 30) + 64'd16384) >> 15);
		end
		return tab;
	endfunction

endpackage

### hdl/wto_stream_if.sv
// Valid/ready channels of the wavetable oscillator: command in, result out.
// Depends on wto_pkg for field widths.
interface wto_cmd_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  command;
	logic [wto_pkg::CUSTOM_ADDR_BITS-1:0]  table_address;
	logic signed [wto_pkg::VALUE_BITS-1:0] table_value;

	modport source (output valid, command, table_address, table_value, input ready);
	modport sink   (input valid, command, table_address, table_value, output ready);
endinterface

interface wto_result_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [wto_pkg::SAMPLE_BITS-1:0] sample;
	logic                                   square_high;

	modport source (output valid, sample, square_high, input ready);
	modport sink   (input valid, sample, square_high, output ready);
endinterface

### hdl/wto_fifo.sv
// Short request queue between the oscillator front and back.
// Depends on wto_pkg for the request type.
module wto_fifo #(
	parameter int DEPTH = wto_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  wto_pkg::op_t din,
	output logic         full,
	input  logic         pop,
	output wto_pkg::op_t dout,
	output logic         empty
);

	localparam int PTR_BITS = $clog2(DEPTH);
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	wto_pkg::op_t        slot_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;

	assign full  = count_q == CNT_BITS'(DEPTH);
	assign empty = count_q == '0;
	assign dout  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_BITS'(push) - CNT_BITS'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(DEPTH))
		else $error("queue count above depth");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == CNT_BITS'($past(count_q) + 1'b1))
		else $error("queue count did not follow a lone push");

endmodule

### hdl/wto_front.sv
// Oscillator front: accepts commands, keeps the phase accumulator, queues requests.
// Depends on wto_pkg and wto_cmd_if.
module wto_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [wto_pkg::PHASE_BITS-1:0]   phase_step,
	wto_cmd_if.sink                          cmd,
	input  logic                             full,
	output logic                             push,
	output wto_pkg::op_t                     op
);

	logic [wto_pkg::PHASE_BITS-1:0] phase_q;

	assign cmd.ready   = !full;
	assign push        = cmd.valid && !full;
	assign op.is_write = cmd.command;
	assign op.value    = cmd.table_value;
	// tick: top bits of the phase; write: the entry to store
	assign op.index    = cmd.command ? cmd.table_address
	                                 : phase_q[wto_pkg::PHASE_BITS-1 -: wto_pkg::INDEX_BITS];

	// advance on ticks only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (push && !cmd.command) begin
			phase_q <= phase_q + phase_step;
		end
	end

endmodule

### hdl/wto_back.sv
// Oscillator back: table lookup, gain multiply, saturation, output register.
// Depends on wto_pkg and wto_result_if; holds the custom table memory.
module wto_back (
	input  logic               clk,
	input  logic               arst_n,
	input  wto_pkg::back_cfg_t cfg,
	input  logic               empty,
	input  wto_pkg::op_t       head,
	output logic               pop,
	wto_result_if.source       result
);

	localparam int IB = wto_pkg::INDEX_BITS;
	localparam int QB = wto_pkg::QTR_BITS;
	localparam int WB = wto_pkg::WAVE_BITS;
	localparam int SB = wto_pkg::SAMPLE_BITS;
	localparam int PB = wto_pkg::PROD_BITS;

	localparam wto_pkg::qtab_t QTAB = wto_pkg::make_qtab();
	localparam logic signed [WB-1:0] FULL_SCALE = WB'(32768);
	localparam logic signed [PB-1:0] SAT_MAX = PB'((1 << (SB - 1)) - 1);
	localparam logic signed [PB-1:0] SAT_MIN = -SAT_MAX - PB'(1);

	logic [wto_pkg::VALUE_BITS-1:0] custom_mem [wto_pkg::CUSTOM_DEPTH];

	logic                 adv;
	logic [1:0]           quad;
	logic [QB-1:0]        qlow;
	logic [QB:0]          qaddr;
	logic signed [WB-1:0] calc;
	logic [WB:0]          tri_v;
	logic [WB:0]          tri_fold;
	logic signed [WB-1:0] wave;
	logic signed [PB-1:0] scaled;
	logic signed [SB-1:0] sat;

	logic                 valid_s1, valid_s2, valid_s3;
	logic                 sq_s1, sq_s2, sq_s3;
	logic                 neg_s1;
	logic [15:0]          qmag_s1;
	logic [wto_pkg::VALUE_BITS-1:0] custom_s1;
	logic signed [WB-1:0] calc_s1;
	logic signed [PB-1:0] prod_s2;
	logic signed [SB-1:0] sample_s3;

	// whole pipeline moves together, held only by the output register
	assign adv = !valid_s3 || result.ready;
	assign pop = adv && !empty;

	assign quad  = head.index[IB-1 -: 2];
	assign qlow  = head.index[QB-1:0];
	assign qaddr = quad[0] ? ((QB + 1)'(wto_pkg::QTR_SIZE) - {1'b0, qlow}) : {1'b0, qlow};

	assign tri_v    = {1'b0, head.index, {wto_pkg::TRI_SHIFT{1'b0}}};
	assign tri_fold = (WB + 1)'(65536) - tri_v;

	always_comb begin
		unique case (cfg.waveform)
			wto_pkg::WAVE_SQUARE:   calc = head.index[IB-1] ? -FULL_SCALE : FULL_SCALE;
			wto_pkg::WAVE_SAWTOOTH: calc = $signed({1'b0, head.index,
			                                        {wto_pkg::SAW_SHIFT{1'b0}}}) - FULL_SCALE;
			// rising quarters keep v; the low bits of v already wrap the last one
			wto_pkg::WAVE_TRIANGLE: calc = (quad == 2'd1 || quad == 2'd2) ?
			                               $signed(tri_fold[WB-1:0]) : $signed(tri_v[WB-1:0]);
			default:                calc = '0;
		endcase
	end

	always_comb begin
		unique case (cfg.waveform)
			wto_pkg::WAVE_SINE:     wave = neg_s1 ? -$signed({1'b0, qmag_s1})
			                                      : $signed({1'b0, qmag_s1});
			wto_pkg::WAVE_CUSTOM:   wave = WB'($signed(custom_s1));
			wto_pkg::WAVE_SQUARE,
			wto_pkg::WAVE_SAWTOOTH,
			wto_pkg::WAVE_TRIANGLE: wave = calc_s1;
			default:                wave = '0;
		endcase
	end

	// floor division by 16384, then clamp
	assign scaled = prod_s2 >>> wto_pkg::GAIN_SHIFT;
	always_comb begin
		priority if (scaled > SAT_MAX) begin
			sat = SB'(SAT_MAX);
		end else if (scaled < SAT_MIN) begin
			sat = SB'(SAT_MIN);
		end else begin
			sat = SB'(scaled);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= pop && !head.is_write;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.is_write) begin
			custom_mem[head.index[wto_pkg::CUSTOM_ADDR_BITS-1:0]] <= head.value;
		end
		if (adv) begin
			custom_s1 <= custom_mem[head.index[wto_pkg::CUSTOM_ADDR_BITS-1:0]];
			qmag_s1   <= QTAB[qaddr];
			neg_s1    <= quad[1];
			sq_s1     <= !head.index[IB-1];
			calc_s1   <= calc;
			prod_s2   <= $signed({1'b0, cfg.gain}) * wave;
			sq_s2     <= sq_s1;
			sample_s3 <= sat;
			sq_s3     <= sq_s2;
		end
	end

	assign result.valid       = valid_s3;
	assign result.sample      = sample_s3;
	assign result.square_high = sq_s3;

	a_square_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && cfg.waveform == wto_pkg::WAVE_SQUARE && cfg.gain != '0)
		|-> (sq_s3 == !sample_s3[SB-1]))
		else $error("square sample sign disagrees with square flag");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> ($stable(prod_s2) && $stable(valid_s2) && $stable(sample_s3)))
		else $error("pipeline moved while output stalled");

endmodule

### hdl/wavetable_oscillator.sv
// Top level of the wavetable oscillator: configuration registers, front, queue, back.
// Depends on wto_pkg, wto_stream_if, wto_front, wto_fifo and wto_back.
//
// Direct digital synthesis oscillator. A tick request (command 0) returns one
// sample: gain times the waveform value at the top ten bits of a 32-bit phase
// accumulator, floored by 16384 and saturated to signed 16 bits, plus a flag
// that is high in the first half of the cycle; the phase then advances by
// phase_step. A write request (command 1) stores table_value in the custom
// table at table_address and returns nothing; write every custom entry before
// selecting the custom waveform. Waveform codes 5 to 7 give a zero sample.
// Requests are taken one per clock while the result side keeps up: the front
// queues each request in a small queue, and the back runs it through a table
// read stage, a multiply stage and the output register. The registered sine
// table and custom memory reads and the single 17x17 gain multiplier set that
// depth. Stalls on the result side back up into the queue and then drop
// ready. Write configuration only while no result is pending.
module wavetable_oscillator #(
	parameter int QUEUE_DEPTH = wto_pkg::QUEUE_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	wto_cmd_if.sink                             cmd,
	wto_result_if.source                        result,
	input  logic                                cfg_we,
	input  logic [wto_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [wto_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

	logic [wto_pkg::PHASE_BITS-1:0]    phase_step_q;
	logic [wto_pkg::GAIN_BITS-1:0]     gain_q;
	logic [wto_pkg::WAVE_SEL_BITS-1:0] waveform_q;

	wto_pkg::back_cfg_t back_cfg;
	wto_pkg::op_t       front_op;
	wto_pkg::op_t       head_op;
	logic               push;
	logic               pop;
	logic               full;
	logic               empty;

	// register file; writes past the last register are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= '0;
			gain_q       <= wto_pkg::GAIN_RESET;
			waveform_q   <= wto_pkg::WAVE_SINE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wto_pkg::REG_PHASE_STEP: phase_step_q <= cfg_wdata[wto_pkg::PHASE_BITS-1:0];
				wto_pkg::REG_GAIN:       gain_q       <= cfg_wdata[wto_pkg::GAIN_BITS-1:0];
				wto_pkg::REG_WAVEFORM:   waveform_q   <= cfg_wdata[wto_pkg::WAVE_SEL_BITS-1:0];
				default:                 ;
			endcase
		end
	end

	assign back_cfg.gain     = gain_q;
	assign back_cfg.waveform = waveform_q;

	// front: classify requests and step the phase
	wto_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.phase_step (phase_step_q),
		.cmd        (cmd),
		.full       (full),
		.push       (push),
		.op         (front_op)
	);

	// queue: lets the command side run ahead of a stalled result side
	wto_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (front_op),
		.full   (full),
		.pop    (pop),
		.dout   (head_op),
		.empty  (empty)
	);

	// back: lookup, scale, saturate, hold the result
	wto_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (back_cfg),
		.empty  (empty),
		.head   (head_op),
		.pop    (pop),
		.result (result)
	);

endmodule
